// ===== src/qpt_pkg.sv =====
// Shared types, widths and constants of the quaternion point transform.
package qpt_pkg;

   // Field and datapath widths
   localparam int COORD_W = 32;
   localparam int QUAT_W  = 32;
   localparam int B_W     = COORD_W + 1;       // point plus mount offset
   localparam int R1_W    = B_W + 1;           // rounded product of b and q
   localparam int T_W     = R1_W + 2;          // t = 2 * (difference)
   localparam int R2_W    = T_W;               // rounded product of t and q
   localparam int C_W     = R2_W + 1;          // cross product term
   localparam int BP_W    = B_W + 1;           // b plus position
   localparam int SUM_W   = C_W + 1;           // full world sum
   localparam int PH_W    = T_W - 16 + QUAT_W; // high partial product
   localparam int PL_W    = 17 + QUAT_W;       // low partial product
   localparam int FULL_W  = PH_W + 16;         // recombined product

   localparam int CSR_IDX_W  = 2;
   localparam int QUEUE_DEPTH = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MOUNT_OFFSET_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOUNT_OFFSET_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MOUNT_OFFSET_Z = 2'd2;

   // Item modes
   localparam logic MODE_POSE  = 1'b0;
   localparam logic MODE_POINT = 1'b1;

   // Constants in fixed point
   localparam logic signed [COORD_W-1:0] MOUNT_OFFSET_Z_RESET = 32'sd10486; // 0.16 m
   localparam logic signed [QUAT_W-1:0]  QUAT_ONE     = 32'sh4000_0000;   // 1.0 in Q1.30
   localparam logic signed [QUAT_W-1:0]  QUAT_NEG_ONE = 32'shC000_0000;   // -1.0 in Q1.30
   localparam logic signed [COORD_W-1:0] COORD_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN    = 32'sh8000_0000;

   // Input beat
   typedef struct packed {
      logic                      mode;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic signed [QUAT_W-1:0]  rot_w;
      logic signed [QUAT_W-1:0]  rot_x;
      logic signed [QUAT_W-1:0]  rot_y;
      logic signed [QUAT_W-1:0]  rot_z;
   } req_type;

   // Result beat
   typedef struct packed {
      logic signed [COORD_W-1:0] world_x;
      logic signed [COORD_W-1:0] world_y;
      logic signed [COORD_W-1:0] world_z;
      logic                      clipped;
   } rsp_type;

   // Classified item between front and back: point sum b, or pose position
   typedef struct packed {
      logic                     mode;
      logic signed [B_W-1:0]    vec_x;
      logic signed [B_W-1:0]    vec_y;
      logic signed [B_W-1:0]    vec_z;
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } entry_type;

endpackage

// ===== src/qpt_if.sv =====
// Valid/ready channel interfaces for input and result beats.
interface qpt_req_if;
   logic              valid;
   logic              ready;
   qpt_pkg::req_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface qpt_rsp_if;
   logic              valid;
   logic              ready;
   qpt_pkg::rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/qpt_queue.sv =====
// Short FIFO that decouples the classifying front from the arithmetic back.
module qpt_queue #(
   parameter int Depth = qpt_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qpt_pkg::entry_type  push_data,
   output logic                full,
   input  logic                pop,
   output qpt_pkg::entry_type  pop_data,
   output logic                empty
);

   localparam int PtrW   = $clog2(Depth);
   localparam int CountW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0]   LastPtr  = PtrW'(Depth - 1);
   localparam logic [CountW-1:0] FullCount = CountW'(Depth);

   qpt_pkg::entry_type storage_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;

   assign full     = (count_ff == FullCount);
   assign empty    = (count_ff == '0);
   assign pop_data = storage_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("queue fill level beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push without pop did not grow the queue");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(pop_data))
      else $error("queue head changed without a pop");
`endif

endmodule

// ===== src/qpt_front.sv =====
// Front end: accepts beats, holds mount offsets, adds them, clamps quaternions.
module qpt_front (
   input  logic                              clock,
   input  logic                              reset,
   qpt_req_if.sink                           req_bus,
   input  logic                              csr_wr_en,
   input  logic [qpt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qpt_pkg::COORD_W-1:0]       csr_wr_data,
   input  logic                              q_full,
   output logic                              push,
   output qpt_pkg::entry_type                push_data
);

   logic signed [qpt_pkg::COORD_W-1:0] offset_x_ff, offset_x_in;
   logic signed [qpt_pkg::COORD_W-1:0] offset_y_ff, offset_y_in;
   logic signed [qpt_pkg::COORD_W-1:0] offset_z_ff, offset_z_in;
   logic                               pose_valid_ff, pose_valid_in;
   logic                               accept;
   logic                               is_pose;

   function automatic logic signed [qpt_pkg::QUAT_W-1:0] clamp_quat(
      input logic signed [qpt_pkg::QUAT_W-1:0] v);
      logic signed [qpt_pkg::QUAT_W-1:0] r;
      r = v;
      if (v > qpt_pkg::QUAT_ONE) begin
         r = qpt_pkg::QUAT_ONE;
      end else if (v < qpt_pkg::QUAT_NEG_ONE) begin
         r = qpt_pkg::QUAT_NEG_ONE;
      end
      return r;
   endfunction

   function automatic logic signed [qpt_pkg::B_W-1:0] add_offset(
      input logic signed [qpt_pkg::COORD_W-1:0] c,
      input logic signed [qpt_pkg::COORD_W-1:0] o,
      input logic                               use_offset);
      logic signed [qpt_pkg::B_W-1:0] r;
      r = qpt_pkg::B_W'(c);
      if (use_offset) begin
         r = qpt_pkg::B_W'(c) + qpt_pkg::B_W'(o);
      end
      return r;
   endfunction

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_pose       = (req_bus.data.mode == qpt_pkg::MODE_POSE);

   // Classify: keep poses, drop points until a pose has arrived
   always_comb begin
      push                = accept && (is_pose || pose_valid_ff);
      pose_valid_in       = pose_valid_ff || (accept && is_pose);
      push_data.mode      = req_bus.data.mode;
      push_data.vec_x     = add_offset(req_bus.data.coord_x, offset_x_ff, !is_pose);
      push_data.vec_y     = add_offset(req_bus.data.coord_y, offset_y_ff, !is_pose);
      push_data.vec_z     = add_offset(req_bus.data.coord_z, offset_z_ff, !is_pose);
      push_data.quat_w    = clamp_quat(req_bus.data.rot_w);
      push_data.quat_x    = clamp_quat(req_bus.data.rot_x);
      push_data.quat_y    = clamp_quat(req_bus.data.rot_y);
      push_data.quat_z    = clamp_quat(req_bus.data.rot_z);
   end

   // Decode register writes; unknown index is dropped
   always_comb begin
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      offset_z_in = offset_z_ff;
      if (csr_wr_en) begin
         case (csr_index)
            qpt_pkg::CSR_MOUNT_OFFSET_X: offset_x_in = csr_wr_data;
            qpt_pkg::CSR_MOUNT_OFFSET_Y: offset_y_in = csr_wr_data;
            qpt_pkg::CSR_MOUNT_OFFSET_Z: offset_z_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff   <= '0;
         offset_y_ff   <= '0;
         offset_z_ff   <= qpt_pkg::MOUNT_OFFSET_Z_RESET;
         pose_valid_ff <= 1'b0;
      end else begin
         offset_x_ff   <= offset_x_in;
         offset_y_ff   <= offset_y_in;
         offset_z_ff   <= offset_z_in;
         pose_valid_ff <= pose_valid_in;
      end
   end

endmodule

// ===== src/qpt_back.sv =====
// Back end: applies poses in order and runs the pipelined rotation datapath.
module qpt_back (
   input  logic                clock,
   input  logic                reset,
   input  qpt_pkg::entry_type  pop_data,
   input  logic                q_empty,
   output logic                pop,
   qpt_rsp_if.source           rsp_bus
);

   localparam int B_W     = qpt_pkg::B_W;
   localparam int R1_W    = qpt_pkg::R1_W;
   localparam int T_W     = qpt_pkg::T_W;
   localparam int R2_W    = qpt_pkg::R2_W;
   localparam int C_W     = qpt_pkg::C_W;
   localparam int BP_W    = qpt_pkg::BP_W;
   localparam int SUM_W   = qpt_pkg::SUM_W;
   localparam int PH_W    = qpt_pkg::PH_W;
   localparam int PL_W    = qpt_pkg::PL_W;
   localparam int FULL_W  = qpt_pkg::FULL_W;
   localparam int COORD_W = qpt_pkg::COORD_W;
   localparam int QUAT_W  = qpt_pkg::QUAT_W;
   localparam logic signed [FULL_W-1:0] RoundHalf = FULL_W'(2**29);

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [QUAT_W-1:0]  quat_w;
      logic signed [QUAT_W-1:0]  quat_x;
      logic signed [QUAT_W-1:0]  quat_y;
      logic signed [QUAT_W-1:0]  quat_z;
   } pose_type;

   typedef struct packed {
      logic signed [PH_W-1:0] hi;
      logic signed [PL_W-1:0] lo;
   } part_type;

   typedef struct packed {
      logic signed [B_W-1:0] b_x;
      logic signed [B_W-1:0] b_y;
      logic signed [B_W-1:0] b_z;
      pose_type              pose;
   } p0_type;

   typedef struct packed {
      logic signed [B_W-1:0] b_x;
      logic signed [B_W-1:0] b_y;
      logic signed [B_W-1:0] b_z;
      pose_type              pose;
      part_type [5:0]        prod;
   } p1_type;

   typedef struct packed {
      logic signed [B_W-1:0]  b_x;
      logic signed [B_W-1:0]  b_y;
      logic signed [B_W-1:0]  b_z;
      pose_type               pose;
      logic [5:0][R1_W-1:0]   r1;
   } p2_type;

   typedef struct packed {
      logic signed [B_W-1:0] b_x;
      logic signed [B_W-1:0] b_y;
      logic signed [B_W-1:0] b_z;
      pose_type              pose;
      logic signed [T_W-1:0] t_x;
      logic signed [T_W-1:0] t_y;
      logic signed [T_W-1:0] t_z;
   } p3_type;

   typedef struct packed {
      logic signed [B_W-1:0] b_x;
      logic signed [B_W-1:0] b_y;
      logic signed [B_W-1:0] b_z;
      pose_type              pose;
      part_type [8:0]        prod;
   } p4_type;

   typedef struct packed {
      logic signed [B_W-1:0] b_x;
      logic signed [B_W-1:0] b_y;
      logic signed [B_W-1:0] b_z;
      pose_type              pose;
      logic [8:0][R2_W-1:0]  r2;
   } p5_type;

   typedef struct packed {
      logic signed [BP_W-1:0] bp_x;
      logic signed [BP_W-1:0] bp_y;
      logic signed [BP_W-1:0] bp_z;
      logic signed [R2_W-1:0] rw_x;
      logic signed [R2_W-1:0] rw_y;
      logic signed [R2_W-1:0] rw_z;
      logic signed [C_W-1:0]  c_x;
      logic signed [C_W-1:0]  c_y;
      logic signed [C_W-1:0]  c_z;
   } p6_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] s_x;
      logic signed [SUM_W-1:0] s_y;
      logic signed [SUM_W-1:0] s_z;
   } p7_type;

   // Split a by 16 bits so each multiplier stays near 32 by 32
   function automatic part_type part_mul(input logic signed [T_W-1:0] a,
                                         input logic signed [QUAT_W-1:0] q);
      logic signed [T_W-17:0] ah;
      logic signed [16:0]     al;
      part_type               p;
      ah   = a[T_W-1:16];
      al   = {1'b0, a[15:0]};
      p.hi = ah * q;
      p.lo = al * q;
      return p;
   endfunction

   // Recombine and round half up to Q.16
   function automatic logic signed [T_W-1:0] round_q30(input part_type p);
      logic signed [FULL_W-1:0] full;
      full = $signed({p.hi, 16'b0}) + FULL_W'(p.lo) + RoundHalf;
      return full[T_W+29:30];
   endfunction

   function automatic logic signed [T_W-1:0] widen_b(input logic signed [B_W-1:0] v);
      return T_W'(v);
   endfunction

   function automatic logic overflow(input logic signed [SUM_W-1:0] v);
      return (v > SUM_W'(qpt_pkg::COORD_MAX)) || (v < SUM_W'(qpt_pkg::COORD_MIN));
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      r = v[COORD_W-1:0];
      if (v > SUM_W'(qpt_pkg::COORD_MAX)) begin
         r = qpt_pkg::COORD_MAX;
      end else if (v < SUM_W'(qpt_pkg::COORD_MIN)) begin
         r = qpt_pkg::COORD_MIN;
      end
      return r;
   endfunction

   pose_type pose_ff, pose_in;
   p0_type   p0_ff, p0_in;
   p1_type   p1_ff, p1_in;
   p2_type   p2_ff, p2_in;
   p3_type   p3_ff, p3_in;
   p4_type   p4_ff, p4_in;
   p5_type   p5_ff, p5_in;
   p6_type   p6_ff, p6_in;
   p7_type   p7_ff, p7_in;
   qpt_pkg::rsp_type out_ff, out_in;
   logic [8:0] valid_ff, valid_in;   // stages p0..p7 and the output register
   logic       advance;
   logic       pop_point;

   // Whole pipeline moves when the output register can take a beat
   assign advance        = !valid_ff[8] || rsp_bus.ready;
   assign pop            = advance && !q_empty;
   assign pop_point      = pop && (pop_data.mode == qpt_pkg::MODE_POINT);
   assign rsp_bus.valid  = valid_ff[8];
   assign rsp_bus.data   = out_ff;
   assign valid_in       = {valid_ff[7:0], pop_point};

   // Commit a pose in queue order; following points see it
   always_comb begin
      pose_in = pose_ff;
      if (pop && (pop_data.mode == qpt_pkg::MODE_POSE)) begin
         pose_in.pos_x  = pop_data.vec_x[COORD_W-1:0];
         pose_in.pos_y  = pop_data.vec_y[COORD_W-1:0];
         pose_in.pos_z  = pop_data.vec_z[COORD_W-1:0];
         pose_in.quat_w = pop_data.quat_w;
         pose_in.quat_x = pop_data.quat_x;
         pose_in.quat_y = pop_data.quat_y;
         pose_in.quat_z = pop_data.quat_z;
      end
   end

   // Capture point with a copy of the current pose
   always_comb begin
      p0_in.b_x  = pop_data.vec_x;
      p0_in.b_y  = pop_data.vec_y;
      p0_in.b_z  = pop_data.vec_z;
      p0_in.pose = pose_ff;
   end

   // First cross product: partial products
   always_comb begin
      p1_in.b_x     = p0_ff.b_x;
      p1_in.b_y     = p0_ff.b_y;
      p1_in.b_z     = p0_ff.b_z;
      p1_in.pose    = p0_ff.pose;
      p1_in.prod[0] = part_mul(widen_b(p0_ff.b_z), p0_ff.pose.quat_y);
      p1_in.prod[1] = part_mul(widen_b(p0_ff.b_y), p0_ff.pose.quat_z);
      p1_in.prod[2] = part_mul(widen_b(p0_ff.b_x), p0_ff.pose.quat_z);
      p1_in.prod[3] = part_mul(widen_b(p0_ff.b_z), p0_ff.pose.quat_x);
      p1_in.prod[4] = part_mul(widen_b(p0_ff.b_y), p0_ff.pose.quat_x);
      p1_in.prod[5] = part_mul(widen_b(p0_ff.b_x), p0_ff.pose.quat_y);
   end

   // First cross product: recombine and round
   always_comb begin
      logic signed [T_W-1:0] rnd;
      p2_in.b_x  = p1_ff.b_x;
      p2_in.b_y  = p1_ff.b_y;
      p2_in.b_z  = p1_ff.b_z;
      p2_in.pose = p1_ff.pose;
      for (int i = 0; i < 6; i++) begin
         rnd         = round_q30(p1_ff.prod[i]);
         p2_in.r1[i] = rnd[R1_W-1:0];
      end
   end

   // Form t = 2 * (q x b)
   always_comb begin
      logic signed [T_W-2:0] d_x;
      logic signed [T_W-2:0] d_y;
      logic signed [T_W-2:0] d_z;
      d_x = (T_W-1)'($signed(p2_ff.r1[0])) - (T_W-1)'($signed(p2_ff.r1[1]));
      d_y = (T_W-1)'($signed(p2_ff.r1[2])) - (T_W-1)'($signed(p2_ff.r1[3]));
      d_z = (T_W-1)'($signed(p2_ff.r1[4])) - (T_W-1)'($signed(p2_ff.r1[5]));
      p3_in.b_x  = p2_ff.b_x;
      p3_in.b_y  = p2_ff.b_y;
      p3_in.b_z  = p2_ff.b_z;
      p3_in.pose = p2_ff.pose;
      p3_in.t_x  = {d_x, 1'b0};
      p3_in.t_y  = {d_y, 1'b0};
      p3_in.t_z  = {d_z, 1'b0};
   end

   // Second cross product and w*t: partial products
   always_comb begin
      p4_in.b_x     = p3_ff.b_x;
      p4_in.b_y     = p3_ff.b_y;
      p4_in.b_z     = p3_ff.b_z;
      p4_in.pose    = p3_ff.pose;
      p4_in.prod[0] = part_mul(p3_ff.t_z, p3_ff.pose.quat_y);
      p4_in.prod[1] = part_mul(p3_ff.t_y, p3_ff.pose.quat_z);
      p4_in.prod[2] = part_mul(p3_ff.t_x, p3_ff.pose.quat_z);
      p4_in.prod[3] = part_mul(p3_ff.t_z, p3_ff.pose.quat_x);
      p4_in.prod[4] = part_mul(p3_ff.t_y, p3_ff.pose.quat_x);
      p4_in.prod[5] = part_mul(p3_ff.t_x, p3_ff.pose.quat_y);
      p4_in.prod[6] = part_mul(p3_ff.t_x, p3_ff.pose.quat_w);
      p4_in.prod[7] = part_mul(p3_ff.t_y, p3_ff.pose.quat_w);
      p4_in.prod[8] = part_mul(p3_ff.t_z, p3_ff.pose.quat_w);
   end

   // Second products: recombine and round
   always_comb begin
      p5_in.b_x  = p4_ff.b_x;
      p5_in.b_y  = p4_ff.b_y;
      p5_in.b_z  = p4_ff.b_z;
      p5_in.pose = p4_ff.pose;
      for (int i = 0; i < 9; i++) begin
         p5_in.r2[i] = round_q30(p4_ff.prod[i]);
      end
   end

   // Cross terms, b plus position, w*t
   always_comb begin
      p6_in.bp_x = BP_W'(p5_ff.b_x) + BP_W'(p5_ff.pose.pos_x);
      p6_in.bp_y = BP_W'(p5_ff.b_y) + BP_W'(p5_ff.pose.pos_y);
      p6_in.bp_z = BP_W'(p5_ff.b_z) + BP_W'(p5_ff.pose.pos_z);
      p6_in.c_x  = C_W'($signed(p5_ff.r2[0])) - C_W'($signed(p5_ff.r2[1]));
      p6_in.c_y  = C_W'($signed(p5_ff.r2[2])) - C_W'($signed(p5_ff.r2[3]));
      p6_in.c_z  = C_W'($signed(p5_ff.r2[4])) - C_W'($signed(p5_ff.r2[5]));
      p6_in.rw_x = $signed(p5_ff.r2[6]);
      p6_in.rw_y = $signed(p5_ff.r2[7]);
      p6_in.rw_z = $signed(p5_ff.r2[8]);
   end

   // Final sums
   always_comb begin
      p7_in.s_x = SUM_W'(p6_ff.bp_x) + SUM_W'(p6_ff.rw_x) + SUM_W'(p6_ff.c_x);
      p7_in.s_y = SUM_W'(p6_ff.bp_y) + SUM_W'(p6_ff.rw_y) + SUM_W'(p6_ff.c_y);
      p7_in.s_z = SUM_W'(p6_ff.bp_z) + SUM_W'(p6_ff.rw_z) + SUM_W'(p6_ff.c_z);
   end

   // Saturate into the output register
   always_comb begin
      out_in.world_x = sat_coord(p7_ff.s_x);
      out_in.world_y = sat_coord(p7_ff.s_y);
      out_in.world_z = sat_coord(p7_ff.s_z);
      out_in.clipped = overflow(p7_ff.s_x) || overflow(p7_ff.s_y) || overflow(p7_ff.s_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         pose_ff.pos_x  <= '0;
         pose_ff.pos_y  <= '0;
         pose_ff.pos_z  <= '0;
         pose_ff.quat_w <= qpt_pkg::QUAT_ONE;
         pose_ff.quat_x <= '0;
         pose_ff.quat_y <= '0;
         pose_ff.quat_z <= '0;
      end else begin
         pose_ff <= pose_in;
         if (advance) begin
            valid_ff <= valid_in;
         end
      end
   end

   // Payload stages, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         p0_ff  <= p0_in;
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         p3_ff  <= p3_in;
         p4_ff  <= p4_in;
         p5_ff  <= p5_in;
         p6_ff  <= p6_in;
         p7_ff  <= p7_in;
         out_ff <= out_in;
      end
   end

endmodule

// ===== src/quaternion_point_transform_core.sv =====
// Top level of the quaternion point transform: front, queue and back.
//
// Moves sensor points into the world frame. A pose beat (mode 0) sets the
// position and the unit quaternion (parts clamped to [-1, 1], no normalizing)
// and gives no result; a point beat (mode 1) gets the mount offset added,
// is rotated as b + w*t + q x t with t = 2*(q x b), gets the position added,
// and comes out as one saturated result with a clipped flag. Points that
// arrive before the first pose are accepted and dropped. The block takes one
// beat and returns at most one result every clock unless the queue is full
// or the result side stalls; points run through the nine-stage back pipeline
// (two rounds of split 20x32 / 17x32 multipliers, each followed by a
// rounding stage). A queue of QueueDepth entries lets input beats keep
// arriving while the result side stalls. The user must write mount offsets
// only while the block is idle; the block does not enforce this.
module quaternion_point_transform_core #(
   parameter int QueueDepth = qpt_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   qpt_req_if.sink                        req_bus,
   qpt_rsp_if.source                      rsp_bus,
   input  logic                           csr_wr_en,
   input  logic [qpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [qpt_pkg::COORD_W-1:0]    csr_wr_data
);

   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;
   qpt_pkg::entry_type push_data;
   qpt_pkg::entry_type pop_data;

   qpt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data)
   );

   qpt_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   qpt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_data (pop_data),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
